>>> design/single_byte_charset_prober_unit_assert.svh
// Assertion macros for the prober checker
`ifndef SINGLE_BYTE_CHARSET_PROBER_UNIT_ASSERT_SVH
`define SINGLE_BYTE_CHARSET_PROBER_UNIT_ASSERT_SVH

// same-cycle implication
`define SBCP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prober check failed");

// next-cycle implication
`define SBCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prober check failed");

`endif

>>> design/sbcp_pkg.sv
`default_nettype none
package sbcp_pkg;
	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_ORDER = 2'd1,
		CMD_PAIR  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DETECTING = 2'd0,
		ST_FOUND     = 2'd1,
		ST_REJECTED  = 2'd2
	} probe_t;

	typedef enum logic [2:0] {
		REG_RATIO  = 3'd0,
		REG_FOUND  = 3'd1,
		REG_REJECT = 3'd2,
		REG_ENOUGH = 3'd3,
		REG_LIMIT  = 3'd4,
		REG_POSCAT = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_EXEC,
		T_PAIR,
		T_UPD,
		T_CONF,
		T_WAIT,
		T_RES
	} top_state_t;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_CMP,
		A_DIV,
		A_DONE
	} arith_state_t;

	localparam logic [9:0] CONF_HIGH = 10'd1013;
	localparam logic [9:0] CONF_LOW  = 10'd10;
	localparam logic [7:0] PREV_RESET = 8'd255;

	localparam logic [15:0] RATIO_RESET  = 16'd62000;
	localparam logic [9:0]  FOUND_RESET  = 10'd972;
	localparam logic [9:0]  REJECT_RESET = 10'd51;
	localparam logic [15:0] ENOUGH_RESET = 16'd1024;
	localparam logic [7:0]  LIMIT_RESET  = 8'd250;
	localparam logic [1:0]  POSCAT_RESET = 2'd3;
endpackage
`default_nettype wire

>>> design/sbcp_arith.sv
`default_nettype none
module sbcp_arith
	import sbcp_pkg::*;
#(
	parameter int COUNTER_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [COUNTER_BITS-1:0] pos,
	input  wire logic [COUNTER_BITS-1:0] freq,
	input  wire logic [COUNTER_BITS-1:0] pairs,
	input  wire logic [COUNTER_BITS-1:0] letters,
	input  wire logic [15:0]             ratio,
	output logic                         done,
	output logic [9:0]                   conf
);
	localparam int W  = 16 + 2 * COUNTER_BITS;
	localparam int CW = $clog2(COUNTER_BITS);
	localparam logic [CW-1:0] MUL_LAST = CW'(COUNTER_BITS - 1);
	localparam logic [CW-1:0] DIV_LAST = CW'(9);

	arith_state_t state_q, state_d;
	logic [W-1:0]            mcand_q, acc_q, num_q, den_q, rem_q;
	logic [COUNTER_BITS-1:0] mplier_q, letters_q;
	logic [CW-1:0]           cnt_q;
	logic [1:0]              phase_q;
	logic [9:0]              quo_q;

	logic [W+1:0] add_a, add_b, sum;
	logic         add_cin, ge;
	logic [W:0]   rem_sh;

	// shared adder: accumulate for multiply, trial subtract for compare and divide
	always_comb begin
		rem_sh = (state_q == A_DIV) ? {rem_q, 1'b0} : {1'b0, num_q};
		if (state_q == A_MUL) begin
			add_a   = {2'b00, acc_q};
			add_b   = {2'b00, mcand_q};
			add_cin = 1'b0;
		end else begin
			add_a   = {1'b0, rem_sh};
			add_b   = ~{2'b00, den_q};
			add_cin = 1'b1;
		end
		sum = add_a + add_b + {{(W+1){1'b0}}, add_cin};
		ge  = ~sum[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: if (start) state_d = (pairs == '0) ? A_DONE : A_MUL;
			A_MUL:  if (cnt_q == MUL_LAST && phase_q == 2'd2) state_d = A_CMP;
			A_CMP:  state_d = (den_q == '0 || ge) ? A_DONE : A_DIV;
			A_DIV:  if (cnt_q == DIV_LAST) state_d = A_DONE;
			A_DONE: state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				mcand_q   <= {{(W-COUNTER_BITS-16){1'b0}}, pos, 16'd0};
				mplier_q  <= freq;
				acc_q     <= '0;
				cnt_q     <= '0;
				phase_q   <= 2'd0;
				letters_q <= letters;
				quo_q     <= CONF_LOW;
			end
			A_MUL: begin
				if (cnt_q == MUL_LAST) begin
					cnt_q   <= '0;
					phase_q <= phase_q + 2'd1;
					acc_q   <= '0;
					unique case (phase_q)
						2'd0: begin
							num_q    <= mplier_q[0] ? sum[W-1:0] : acc_q;
							mcand_q  <= {{(W-COUNTER_BITS){1'b0}}, pairs};
							mplier_q <= {{(COUNTER_BITS-16){1'b0}}, ratio};
						end
						2'd1: begin
							mcand_q  <= mplier_q[0] ? sum[W-1:0] : acc_q;
							mplier_q <= letters_q;
						end
						default: den_q <= mplier_q[0] ? sum[W-1:0] : acc_q;
					endcase
				end else begin
					cnt_q    <= cnt_q + CW'(1);
					if (mplier_q[0]) acc_q <= sum[W-1:0];
					mcand_q  <= {mcand_q[W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[COUNTER_BITS-1:1]};
				end
			end
			A_CMP: begin
				rem_q <= num_q;
				cnt_q <= '0;
				if (den_q == '0) begin
					quo_q <= (num_q == '0) ? 10'd0 : CONF_HIGH;
				end else if (ge) begin
					quo_q <= CONF_HIGH;
				end else begin
					quo_q <= '0;
				end
			end
			A_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				quo_q <= {quo_q[8:0], ge};
				rem_q <= ge ? sum[W-1:0] : rem_sh[W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == A_DONE);
	assign conf = quo_q;
endmodule
`default_nettype wire

>>> design/single_byte_charset_prober_unit.sv
// Channel  Dir  Fields (low bit up)                                  Handshake
// s_axis   in   tdata: byte_value, table_index, table_value;         tvalid/tready
//               tuser: cmd; tlast: chunk_end
// m_axis   out  tdata: detect_state, confidence                      tvalid/tready
// cfg      in   cfg_index, cfg_data                                  cfg_we
//
// A data byte passes accept, order read, pair read and count update; table writes
// and clears pass accept and execute. A chunk end then runs the confidence unit,
// whose shared adder does three serial multiplies, one compare and, unless the
// compare decides, ten divide steps. s_axis_tready is high only while idle.
// The result sits in an output register; a stalled m_axis holds only the next
// chunk-end result. Reset clears control and counters; tables need loading.
`default_nettype none
module single_byte_charset_prober_unit
	import sbcp_pkg::*;
#(
	parameter int SAMPLE_ORDERS  = 64,
	parameter int CATEGORY_COUNT = 4,
	parameter int COUNTER_BITS   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // byte_value, table_index, table_value
	input  wire logic [1:0]  s_axis_tuser,  // cmd
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // detect_state, confidence
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int PAIR_DEPTH = SAMPLE_ORDERS * SAMPLE_ORDERS;
	localparam int PAW = $clog2(PAIR_DEPTH);
	localparam logic [7:0]  SAMPLE_LIM = 8'(SAMPLE_ORDERS);
	localparam logic [12:0] PAIR_LIM   = 13'(PAIR_DEPTH);

	top_state_t state_q, state_d;

	logic [15:0] ratio_q, enough_q;
	logic [9:0]  found_q, reject_q;
	logic [7:0]  limit_q;
	logic [1:0]  poscat_q;

	logic [1:0]  cmd_q;
	logic [7:0]  byte_q, tval_q;
	logic [11:0] idx_q;
	logic        last_q;

	logic [7:0] order_mem [256];
	logic [1:0] pair_mem [PAIR_DEPTH];
	logic [7:0] ord_q, prev_q;
	logic [1:0] pcat_q;
	logic       pair_hit_q;
	logic [15:0] pair_addr_full;

	logic [COUNTER_BITS-1:0] cat_cnt_q [CATEGORY_COUNT];
	logic [COUNTER_BITS-1:0] pair_q, letter_q, freq_q, pos;
	probe_t probe_q;

	logic       arith_done;
	logic [9:0] arith_conf;
	logic [9:0] conf_q;
	logic       accept;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == T_IDLE);
	assign pair_addr_full = 16'(prev_q) * 16'(SAMPLE_ORDERS) + 16'(ord_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RESET;
			found_q  <= FOUND_RESET;
			reject_q <= REJECT_RESET;
			enough_q <= ENOUGH_RESET;
			limit_q  <= LIMIT_RESET;
			poscat_q <= POSCAT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATIO:  ratio_q  <= cfg_data;
				REG_FOUND:  found_q  <= cfg_data[9:0];
				REG_REJECT: reject_q <= cfg_data[9:0];
				REG_ENOUGH: enough_q <= cfg_data;
				REG_LIMIT:  limit_q  <= cfg_data[7:0];
				REG_POSCAT: poscat_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_axis_tuser;
			byte_q <= s_axis_tdata[7:0];
			idx_q  <= s_axis_tdata[19:8];
			tval_q <= s_axis_tdata[27:20];
			last_q <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_EXEC && cmd_q == CMD_ORDER && idx_q[11:8] == 4'd0) begin
			order_mem[idx_q[7:0]] <= tval_q;
		end
		ord_q <= order_mem[byte_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == T_EXEC && cmd_q == CMD_PAIR && {1'b0, idx_q} < PAIR_LIM) begin
			pair_mem[idx_q[PAW-1:0]] <= tval_q[1:0];
		end
		pcat_q <= pair_mem[pair_addr_full[PAW-1:0]];
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < CATEGORY_COUNT; i++) begin
			if (poscat_q == 2'(i)) pos = cat_cnt_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: if (accept) state_d = T_EXEC;
			T_EXEC: state_d = (cmd_q == CMD_DATA) ? T_PAIR : (last_q ? T_CONF : T_IDLE);
			T_PAIR: state_d = T_UPD;
			T_UPD:  state_d = last_q ? T_CONF : T_IDLE;
			T_CONF: state_d = T_WAIT;
			T_WAIT: if (arith_done) state_d = T_RES;
			T_RES:  if (!m_axis_tvalid || m_axis_tready) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= PREV_RESET;
			pair_q     <= '0;
			letter_q   <= '0;
			freq_q     <= '0;
			probe_q    <= ST_DETECTING;
			pair_hit_q <= 1'b0;
			conf_q     <= '0;
			for (int i = 0; i < CATEGORY_COUNT; i++) cat_cnt_q[i] <= '0;
		end else begin
			unique case (state_q)
				T_EXEC: begin
					if (cmd_q == CMD_CLEAR) begin
						prev_q   <= PREV_RESET;
						pair_q   <= '0;
						letter_q <= '0;
						freq_q   <= '0;
						probe_q  <= ST_DETECTING;
						for (int i = 0; i < CATEGORY_COUNT; i++) cat_cnt_q[i] <= '0;
					end
				end
				T_PAIR: begin
					if (ord_q < limit_q && !(&letter_q)) letter_q <= letter_q + 1'b1;
					if (ord_q < SAMPLE_LIM && !(&freq_q)) freq_q <= freq_q + 1'b1;
					pair_hit_q <= (ord_q < SAMPLE_LIM) && (prev_q < SAMPLE_LIM);
				end
				T_UPD: begin
					prev_q <= ord_q;
					if (pair_hit_q) begin
						if (!(&pair_q)) pair_q <= pair_q + 1'b1;
						for (int i = 0; i < CATEGORY_COUNT; i++) begin
							if (pcat_q == 2'(i) && !(&cat_cnt_q[i])) begin
								cat_cnt_q[i] <= cat_cnt_q[i] + 1'b1;
							end
						end
					end
				end
				T_WAIT: begin
					if (arith_done) begin
						conf_q <= arith_conf;
						if (probe_q == ST_DETECTING &&
						    pair_q > {{(COUNTER_BITS-16){1'b0}}, enough_q}) begin
							if (arith_conf > found_q) probe_q <= ST_FOUND;
							else if (arith_conf < reject_q) probe_q <= ST_REJECTED;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == T_RES && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_RES && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= {4'd0, conf_q, probe_q};
		end
	end

	sbcp_arith #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_arith (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == T_CONF),
		.pos     (pos),
		.freq    (freq_q),
		.pairs   (pair_q),
		.letters (letter_q),
		.ratio   (ratio_q),
		.done    (arith_done),
		.conf    (arith_conf)
	);
endmodule
`default_nettype wire

>>> design/sbcp_checker.sv
`default_nettype none
`include "single_byte_charset_prober_unit_assert.svh"
module sbcp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);
	`SBCP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`SBCP_ASSERT_NOW(a_conf_cap, m_axis_tvalid, m_axis_tdata[11:2] <= 10'd1013)
	`SBCP_ASSERT_NOW(a_state_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
	`SBCP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind single_byte_charset_prober_unit sbcp_checker u_sbcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
